// ===== rtl/core/lpf_pkg.sv =====
// Shared types, constants and helpers for the Lennard-Jones pair force block.
// Used by every module under rtl/core; depends on nothing.
package lpf_pkg;

  localparam int POS_W    = 24;
  localparam int D_W      = 26;
  localparam int R2_W     = 52;
  localparam int PW_W     = 32;
  localparam int F_W      = 32;
  localparam int ACC_W    = 48;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_STEPS = 31;

  localparam logic [R2_W-1:0] R2_FLOOR = 52'd3865470566;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;

  localparam logic [POS_W-1:0] BOX_RESET = 24'd1048576;

  typedef struct packed {
    logic [POS_W-1:0] pos_a_x;
    logic [POS_W-1:0] pos_a_y;
    logic [POS_W-1:0] pos_a_z;
    logic [POS_W-1:0] pos_b_x;
    logic [POS_W-1:0] pos_b_y;
    logic [POS_W-1:0] pos_b_z;
    logic             same_cell;
    logic             start_step;
  } lpf_in_t;

  typedef struct packed {
    logic signed [F_W-1:0]   force_x;
    logic signed [F_W-1:0]   force_y;
    logic signed [F_W-1:0]   force_z;
    logic signed [ACC_W-1:0] energy_total;
    logic signed [ACC_W-1:0] virial_total;
  } lpf_out_t;

  // Classified pair handed from front to back
  typedef struct packed {
    logic signed [D_W-1:0] d_x;
    logic signed [D_W-1:0] d_y;
    logic signed [D_W-1:0] d_z;
    logic [R2_W-1:0]       r2;
    logic                  same_cell;
    logic                  start_step;
  } lpf_pair_t;

  // Pick the smallest of d-L, d, d+L; d wins ties
  function automatic logic signed [D_W-1:0] min_image(input logic [POS_W-1:0] a,
                                                      input logic [POS_W-1:0] b,
                                                      input logic [POS_W-1:0] len);
    logic signed [D_W-1:0] d, lo, hi;
    logic [D_W-1:0] ad, al, ah;
    d  = $signed({2'b00, a}) - $signed({2'b00, b});
    lo = d - $signed({2'b00, len});
    hi = d + $signed({2'b00, len});
    ad = d[D_W-1] ? D_W'(-d) : D_W'(d);
    al = lo[D_W-1] ? D_W'(-lo) : D_W'(lo);
    ah = hi[D_W-1] ? D_W'(-hi) : D_W'(hi);
    if (ad <= al && ad <= ah) return d;
    return (al < ah) ? lo : hi;
  endfunction

  function automatic logic signed [F_W-1:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) return 32'sh7fffffff;
    if (v < -44'sd2147483648) return 32'sh80000000;
    return v[F_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat48(input logic signed [49:0] v);
    if (v > 50'sd140737488355327) return 48'sh7fffffffffff;
    if (v < -50'sd140737488355328) return 48'sh800000000000;
    return v[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/core/lpf_front.sv =====
// Front end: accepts position pairs, applies the minimum image, forms r squared.
// Depends on lpf_pkg.
module lpf_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  lpf_pkg::lpf_in_t       in_data,
  output logic                   in_full,
  input  logic [lpf_pkg::POS_W-1:0] box_x,
  input  logic [lpf_pkg::POS_W-1:0] box_y,
  input  logic [lpf_pkg::POS_W-1:0] box_z,
  output logic                   q_push,
  output lpf_pkg::lpf_pair_t     q_data,
  input  logic                   q_full
);
  import lpf_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_SQ   = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;
  logic signed [D_W-1:0] d_r [3];
  logic [R2_W-1:0] r2_r, r2_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic same_r, start_r;
  logic accept;
  logic signed [D_W-1:0] d_sel;
  logic signed [2*D_W-1:0] sq;

  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && !in_full;
  assign d_sel   = d_r[axis_r];
  assign sq      = d_sel * d_sel;

  // Sequence: latch images, square three axes, hand over
  always_comb begin
    state_nxt = state_r;
    r2_nxt    = r2_r;
    axis_nxt  = axis_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_SQ;
          r2_nxt    = '0;
          axis_nxt  = '0;
        end
      end
      F_SQ: begin
        r2_nxt   = r2_r + R2_W'(sq);
        axis_nxt = axis_r + 2'd1;
        if (axis_r == 2'd2) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        q_push = !q_full;
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    r2_r   <= r2_nxt;
    axis_r <= axis_nxt;
    if (accept) begin
      d_r[0]  <= min_image(in_data.pos_a_x, in_data.pos_b_x, box_x);
      d_r[1]  <= min_image(in_data.pos_a_y, in_data.pos_b_y, box_y);
      d_r[2]  <= min_image(in_data.pos_a_z, in_data.pos_b_z, box_z);
      same_r  <= in_data.same_cell;
      start_r <= in_data.start_step;
    end
  end

  // Floor r squared at 0.9
  always_comb begin
    q_data.d_x        = d_r[0];
    q_data.d_y        = d_r[1];
    q_data.d_z        = d_r[2];
    q_data.r2         = (r2_r < R2_FLOOR) ? R2_FLOOR : r2_r;
    q_data.same_cell  = same_r;
    q_data.start_step = start_r;
  end

endmodule

// ===== rtl/core/lpf_pair_q.sv =====
// Two-entry queue of classified pairs between front and back.
// Depends on lpf_pkg.
module lpf_pair_q (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpf_pkg::lpf_pair_t push_data,
  output logic               full,
  input  logic               pop,
  output lpf_pkg::lpf_pair_t pop_data,
  output logic               empty
);
  import lpf_pkg::*;

  lpf_pair_t mem_r [2];
  logic wr_r, rd_r;
  logic [1:0] cnt_r;
  logic do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop)  rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

// ===== rtl/core/lpf_back.sv =====
// Back end: reciprocal, powers, forces, energy and virial sums, result queue.
// Depends on lpf_pkg.
module lpf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  lpf_pkg::lpf_pair_t q_data,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output lpf_pkg::lpf_out_t  out_data
);
  import lpf_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_DIV   = 7'b0000010,
    B_POW   = 7'b0000100,
    B_COEF  = 7'b0001000,
    B_FORCE = 7'b0010000,
    B_VIR   = 7'b0100000,
    B_DONE  = 7'b1000000
  } back_state_t;

  back_state_t state_r, state_nxt;
  lpf_pair_t pair_r;
  logic [R2_W-1:0] rem_r;
  logic [R2_W:0] rem_sh;
  logic div_ge;
  logic [30:0] quo_r;
  logic [4:0] cnt_r, cnt_nxt;
  logic [PW_W-1:0] s_r, s2_r, s3_r, s4_r, s6_r, s7_r;
  logic [PW_W-1:0] ma, mb;
  logic [2*PW_W-1:0] mprod;
  logic signed [39:0] c_r;
  logic signed [35:0] e_r;
  logic signed [34:0] cdiff;
  logic signed [33:0] ediff;
  logic signed [35:0] ew;
  logic signed [D_W-1:0] d_arr [3];
  logic signed [D_W-1:0] d_sel;
  logic signed [F_W-1:0] f_r [3];
  logic signed [65:0] fprod;
  logic signed [57:0] vprod;
  logic signed [59:0] vsum_r;
  logic signed [ACC_W-1:0] energy_acc_r, virial_acc_r;
  logic signed [ACC_W-1:0] e_base, v_base, e_new, v_new;
  logic [1:0] axis;
  lpf_out_t oq_mem_r [2];
  logic oq_wr_r, oq_rd_r;
  logic [1:0] oq_cnt_r;
  logic oq_full, oq_push, oq_pop;

  assign d_arr[0] = pair_r.d_x;
  assign d_arr[1] = pair_r.d_y;
  assign d_arr[2] = pair_r.d_z;
  assign axis     = cnt_r[1:0];
  assign d_sel    = d_arr[axis];

  // Restoring divide step for 2^62 / r2
  assign rem_sh = {rem_r, 1'b0};
  assign div_ge = (rem_sh >= {1'b0, pair_r.r2});

  // Shared multiplier for the power chain
  always_comb begin
    case (cnt_r[2:0])
      3'd0:    begin ma = s_r;  mb = s_r;  end
      3'd1:    begin ma = s2_r; mb = s_r;  end
      3'd2:    begin ma = s2_r; mb = s2_r; end
      3'd3:    begin ma = s3_r; mb = s3_r; end
      default: begin ma = s6_r; mb = s_r;  end
    endcase
  end
  assign mprod = ma * mb;

  // Coefficient and energy term
  assign cdiff = $signed({2'b00, s7_r, 1'b0}) - $signed({3'b000, s4_r});
  assign ediff = $signed({2'b00, s6_r}) - $signed({2'b00, s3_r});
  assign ew    = pair_r.same_cell ? (36'(ediff) <<< 2) : (36'(ediff) <<< 1);

  assign fprod = c_r * d_sel;
  assign vprod = f_r[axis] * d_sel;

  // Fold this pair into the running sums, restarting them on start_step
  assign e_base = pair_r.start_step ? '0 : energy_acc_r;
  assign v_base = pair_r.start_step ? '0 : virial_acc_r;
  assign e_new  = sat48(50'(e_base) + 50'(e_r >>> 6));
  assign v_new  = sat48(50'(v_base) + 50'(vsum_r >>> 16));

  assign oq_full = (oq_cnt_r == 2'd2);
  assign out_empty = (oq_cnt_r == 2'd0);
  assign oq_pop  = out_pop && !out_empty;
  assign out_data = oq_mem_r[oq_rd_r];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    oq_push   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_DIV;
          cnt_nxt   = '0;
        end
      end
      B_DIV: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          state_nxt = B_POW;
          cnt_nxt   = '0;
        end
      end
      B_POW: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd4) state_nxt = B_COEF;
      end
      B_COEF: begin
        state_nxt = B_FORCE;
        cnt_nxt   = '0;
      end
      B_FORCE: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) begin
          state_nxt = B_VIR;
          cnt_nxt   = '0;
        end
      end
      B_VIR: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd2) state_nxt = B_DONE;
      end
      B_DONE: begin
        oq_push = !oq_full;
        if (!oq_full) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      energy_acc_r <= '0;
      virial_acc_r <= '0;
      oq_wr_r      <= 1'b0;
      oq_rd_r      <= 1'b0;
      oq_cnt_r     <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (oq_push) begin
        energy_acc_r <= e_new;
        virial_acc_r <= v_new;
        oq_wr_r      <= !oq_wr_r;
      end
      if (oq_pop) oq_rd_r <= !oq_rd_r;
      oq_cnt_r <= oq_cnt_r + {1'b0, oq_push} - {1'b0, oq_pop};
    end
    cnt_r <= cnt_nxt;
    if (q_pop) begin
      pair_r <= q_data;
      rem_r  <= 52'h0_0000_8000_0000;
    end
    if (state_r == B_DIV) begin
      rem_r <= div_ge ? R2_W'(rem_sh - {1'b0, pair_r.r2}) : rem_sh[R2_W-1:0];
      quo_r <= {quo_r[29:0], div_ge};
      if (cnt_r == 5'(DIV_STEPS - 1)) s_r <= {1'b0, quo_r[29:0], div_ge};
    end
    if (state_r == B_POW) begin
      case (cnt_r[2:0])
        3'd0:    s2_r <= mprod[61:30];
        3'd1:    s3_r <= mprod[61:30];
        3'd2:    s4_r <= mprod[61:30];
        3'd3:    s6_r <= mprod[61:30];
        default: s7_r <= mprod[61:30];
      endcase
    end
    if (state_r == B_COEF) begin
      c_r    <= (40'(cdiff) <<< 4) + (40'(cdiff) <<< 3);
      e_r    <= ew;
      vsum_r <= '0;
    end
    if (state_r == B_FORCE) f_r[axis] <= sat32(44'(fprod >>> 22));
    if (state_r == B_VIR) vsum_r <= vsum_r + 60'(vprod);
    if (oq_push) begin
      oq_mem_r[oq_wr_r] <= '{force_x: f_r[0], force_y: f_r[1], force_z: f_r[2],
                             energy_total: e_new, virial_total: v_new};
    end
  end

  // Checks
  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n) oq_cnt_r <= 2'd2)
    else $error("result queue overfilled");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == B_DIV) |=> (state_r == B_DIV || state_r == B_POW))
    else $error("divide left early");
  a_recip_fit: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == B_POW) |-> (s_r[PW_W-1] == 1'b0))
    else $error("reciprocal out of range");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
      $fell(out_empty) |-> $past(state_r == B_DONE))
    else $error("result without finished pair");

endmodule

// ===== rtl/core/lj_pair_force_min_image.sv =====
// Top level of the Lennard-Jones pair force block with minimum image.
// Depends on lpf_pkg, lpf_front, lpf_pair_q, lpf_back.
//
//  channel | ports                               | handshake
//  input   | in_push, in_full, in_data           | push && !full
//  result  | out_pop, out_empty, out_data        | pop && !empty
//  config  | cfg_valid, cfg_ready, cfg_index/data | valid && ready
//
// In the back end each pair goes through, in order: taking it from the queue,
// the 31-step reciprocal divider, five power products, one coefficient step,
// six force/virial steps and writing the result. The front end takes no new
// pair before handing on the last; a two-entry queue lets it run ahead.
// Reset is synchronous, active low; box lengths return to 16.0, sums to zero.
// A full result queue stalls the back end at its final step.
module lj_pair_force_min_image (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  lpf_pkg::lpf_in_t              in_data,
  output logic                          in_full,
  input  logic                          out_pop,
  output logic                          out_empty,
  output lpf_pkg::lpf_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpf_pkg::POS_W-1:0]     cfg_data
);
  import lpf_pkg::*;

  logic [POS_W-1:0] box_x_r, box_y_r, box_z_r;
  logic mq_push, mq_full, mq_pop, mq_empty;
  lpf_pair_t mq_in, mq_out;

  assign cfg_ready = 1'b1;

  // Hold box lengths; drop writes beyond box_z
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= BOX_RESET;
      box_y_r <= BOX_RESET;
      box_z_r <= BOX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOX_X: box_x_r <= cfg_data;
        CFG_BOX_Y: box_y_r <= cfg_data;
        CFG_BOX_Z: box_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lpf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .box_x   (box_x_r),
    .box_y   (box_y_r),
    .box_z   (box_z_r),
    .q_push  (mq_push),
    .q_data  (mq_in),
    .q_full  (mq_full)
  );

  lpf_pair_q u_pair_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mq_push),
    .push_data (mq_in),
    .full      (mq_full),
    .pop       (mq_pop),
    .pop_data  (mq_out),
    .empty     (mq_empty)
  );

  lpf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (mq_empty),
    .q_data    (mq_out),
    .q_pop     (mq_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule
